// ===== hdl/lds_pkg.sv =====
// Shared types, constants and helpers for the LED driver frame serialiser.
// Used by lds_packer and led_driver_frame_serializer; no dependencies.
`default_nettype none

package lds_pkg;

	// frame geometry
	localparam int CHUNK_W    = 64;
	localparam int NUM_LEDS   = 16;
	localparam int ROW_AW     = 4;
	localparam int GS_W       = 16;
	localparam int DC_W       = 7;
	localparam int DC_ENTRIES = 48;
	localparam int GS_ROW_W   = 3 * GS_W;
	localparam int DC_ROW_W   = 3 * DC_W;
	localparam int PUSH_W     = GS_ROW_W;
	localparam int ACC_W      = CHUNK_W + PUSH_W;
	localparam int CNT_W      = 7;
	localparam int LEN_W      = 6;
	localparam int STEP_W     = 5;
	localparam int CFG_DW     = 32;

	// item kinds
	localparam logic [1:0] KIND_GS   = 2'd0;
	localparam logic [1:0] KIND_DC   = 2'd1;
	localparam logic [1:0] KIND_CTRL = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FUNC = 2'd0;
	localparam logic [1:0] REG_BRT  = 2'd1;
	localparam logic [1:0] REG_MAXC = 2'd2;

	localparam logic [4:0]  FUNC_RESET = 5'd23;
	localparam logic [20:0] BRT_RESET  = 21'd16513;
	localparam logic [8:0]  MAXC_RESET = 9'd365;
	localparam logic [DC_W-1:0] DC_RESET = 7'h7f;

	localparam logic [7:0] CTRL_MAGIC = 8'h96;

	// feed steps of each frame kind
	localparam logic [STEP_W-1:0] STEP_HEAD      = 5'd0;
	localparam logic [STEP_W-1:0] GS_LAST_STEP   = 5'd16;
	localparam logic [STEP_W-1:0] CT_ONES_LAST   = 5'd8;
	localparam logic [STEP_W-1:0] CT_ONES_TAIL   = 5'd9;
	localparam logic [STEP_W-1:0] CT_CFG_STEP    = 5'd10;
	localparam logic [STEP_W-1:0] CT_LAST_STEP   = 5'd26;

	localparam logic [LEN_W-1:0] LEN_GS_HEAD = 6'd1;
	localparam logic [LEN_W-1:0] LEN_CT_HEAD = 6'd9;
	localparam logic [LEN_W-1:0] LEN_FULL    = 6'd48;
	localparam logic [LEN_W-1:0] LEN_ONES    = 6'd5;
	localparam logic [LEN_W-1:0] LEN_CFG     = 6'd35;
	localparam logic [LEN_W-1:0] LEN_DC_ROW  = 6'd21;

	localparam logic [CNT_W-1:0] CHUNK_CNT = 7'd64;

	// divide by three through a reciprocal, exact for six-bit inputs
	localparam logic [11:0] DIV3_MUL = 12'd43;
	localparam int          DIV3_SH  = 7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  led;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [5:0]  dc_index;
		logic [6:0]  dc_value;
	} cmd_t;

	typedef struct packed {
		logic [63:0] frame_chunk;
		logic [6:0]  bit_count;
		logic        latch;
	} result_t;

	// bits handed to the packer, left aligned, zero below len
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [PUSH_W-1:0] data;
	} push_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DCWR = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	function automatic logic [4:0] dc_row(input logic [5:0] idx);
		logic [11:0] p;
		p = 12'(idx) * DIV3_MUL;
		return p[11:DIV3_SH];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lds_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/lds_packer.sv =====
// Bit packer: gathers variable-length pushes and emits 64-bit chunks.
// Depends on lds_pkg.
`default_nettype none

module lds_packer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lds_pkg::push_t push,
	output logic                strobe,
	output lds_pkg::result_t    result,
	output logic                fin
);

	// valid bits sit at the top of acc_q; everything below count_q is zero
	logic [lds_pkg::ACC_W-1:0] acc_q;
	logic [lds_pkg::CNT_W-1:0] count_q;
	logic                      done_q;

	logic                      emit;
	logic                      full;
	logic [lds_pkg::ACC_W-1:0] base_acc;
	logic [lds_pkg::CNT_W-1:0] base_cnt;
	logic [lds_pkg::ACC_W-1:0] ins;
	logic [lds_pkg::ACC_W-1:0] acc_d;
	logic [lds_pkg::CNT_W-1:0] cnt_d;

	always_comb begin
		full     = count_q >= lds_pkg::CHUNK_CNT;
		fin      = done_q && !full && (count_q != '0) || done_q && count_q == lds_pkg::CHUNK_CNT;
		emit     = full || fin;
		base_acc = emit ? {acc_q[lds_pkg::PUSH_W-1:0], {lds_pkg::CHUNK_W{1'b0}}} : acc_q;
		base_cnt = full ? count_q - lds_pkg::CHUNK_CNT : (fin ? '0 : count_q);
		ins      = {push.data, {lds_pkg::CHUNK_W{1'b0}}} >> base_cnt;
		acc_d    = push.vld ? (base_acc | ins) : base_acc;
		cnt_d    = push.vld ? base_cnt + lds_pkg::CNT_W'(push.len) : base_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			acc_q   <= acc_d;
			count_q <= cnt_d;
			if (push.vld && push.last) begin
				done_q <= 1'b1;
			end else if (fin) begin
				done_q <= 1'b0;
			end
			strobe <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.frame_chunk <= acc_q[lds_pkg::ACC_W-1 -: lds_pkg::CHUNK_W];
			result.bit_count   <= fin ? count_q : lds_pkg::CHUNK_CNT;
			result.latch       <= fin;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/led_driver_frame_serializer.sv =====
// Top level of the LED driver frame serialiser: sequencer, stores, config.
// Depends on lds_pkg, lds_ram and lds_packer.
`default_nettype none

// A command is taken when start is high and busy is low; busy stays high until the
// last chunk of its frame is on the result port. A grayscale or control frame is 769
// bits, delivered as 13 strobed chunks (twelve of 64 bits, then one bit with latch set).
// The receiver cannot stall: each chunk is valid for exactly one cycle. A grayscale
// or control command keeps busy high while the feed reads one memory row per cycle
// (one LED, 48 bits, or three dot-correction entries, 21 bits) into the packer, through
// the read latency and while the packer drains its last two chunks. A dot-correction
// write gives no result; it reads the row while idle, then merges and writes it back.
// Stores come out of reset at their default contents at once; no clearing pass is needed.
module led_driver_frame_serializer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire lds_pkg::cmd_t               cmd,
	output logic                             strobe,
	output lds_pkg::result_t                 result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [lds_pkg::CFG_DW-1:0]  cfg_data
);

	lds_pkg::state_t state_q, state_d;

	logic                         accept;
	logic                         pk_fin;
	lds_pkg::push_t               push;

	logic [4:0]                   fn_q;
	logic [20:0]                  bw_q;
	logic [8:0]                   mc_q;

	logic [lds_pkg::NUM_LEDS-1:0] gs_vld_q;
	logic [lds_pkg::NUM_LEDS-1:0] dc_vld_q;

	logic                         frame_ctrl_q;
	logic                         feed_q;
	logic [lds_pkg::STEP_W-1:0]   step_q;
	logic [lds_pkg::STEP_W-1:0]   last_step;
	logic [lds_pkg::STEP_W-1:0]   row_full;
	logic [lds_pkg::ROW_AW-1:0]   frame_row;

	logic                         vld_s1;
	logic                         ctrl_s1;
	logic                         rvld_s1;
	logic                         last_s1;
	logic [lds_pkg::STEP_W-1:0]   step_s1;

	logic [4:0]                   cmd_row;
	logic [1:0]                   cmd_slot;
	logic [lds_pkg::ROW_AW-1:0]   dc_row_q;
	logic [1:0]                   dc_slot_q;
	logic [lds_pkg::DC_W-1:0]     dc_val_q;

	logic                         gs_we;
	logic [lds_pkg::GS_ROW_W-1:0] gs_rdata;
	logic                         dc_we;
	logic [lds_pkg::ROW_AW-1:0]   dc_raddr;
	logic [lds_pkg::DC_ROW_W-1:0] dc_rdata;
	logic [lds_pkg::DC_ROW_W-1:0] dc_base;
	logic [lds_pkg::DC_ROW_W-1:0] dc_wdata;

	assign accept    = start && !busy;
	assign busy      = state_q != lds_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q <= lds_pkg::FUNC_RESET;
			bw_q <= lds_pkg::BRT_RESET;
			mc_q <= lds_pkg::MAXC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lds_pkg::REG_FUNC: fn_q <= cfg_data[4:0];
				lds_pkg::REG_BRT:  bw_q <= cfg_data[20:0];
				lds_pkg::REG_MAXC: mc_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cmd_row  = lds_pkg::dc_row(cmd.dc_index);
	assign cmd_slot = 2'(cmd.dc_index - 6'({1'b0, cmd_row} * 6'd3));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lds_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.kind == lds_pkg::KIND_GS || cmd.kind == lds_pkg::KIND_CTRL) begin
						state_d = lds_pkg::ST_RUN;
					end else if (cmd.kind == lds_pkg::KIND_DC &&
						cmd.dc_index < 6'(lds_pkg::DC_ENTRIES)) begin
						state_d = lds_pkg::ST_DCWR;
					end
				end
			end
			lds_pkg::ST_DCWR: state_d = lds_pkg::ST_IDLE;
			lds_pkg::ST_RUN: begin
				if (pk_fin) begin
					state_d = lds_pkg::ST_IDLE;
				end
			end
			default: state_d = lds_pkg::ST_IDLE;
		endcase
	end

	// feed counter: one step per cycle, rows read in descending order
	assign last_step = frame_ctrl_q ? lds_pkg::CT_LAST_STEP : lds_pkg::GS_LAST_STEP;
	assign row_full  = last_step - step_q;
	assign frame_row = row_full[lds_pkg::ROW_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lds_pkg::ST_IDLE;
			feed_q       <= 1'b0;
			step_q       <= '0;
			frame_ctrl_q <= 1'b0;
			vld_s1       <= 1'b0;
			gs_vld_q     <= '0;
			dc_vld_q     <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == lds_pkg::ST_RUN) && feed_q;
			if (state_q == lds_pkg::ST_IDLE && state_d == lds_pkg::ST_RUN) begin
				feed_q       <= 1'b1;
				step_q       <= lds_pkg::STEP_HEAD;
				frame_ctrl_q <= cmd.kind == lds_pkg::KIND_CTRL;
			end else if (state_q == lds_pkg::ST_RUN && feed_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == last_step) begin
					feed_q <= 1'b0;
				end
			end
			if (gs_we) begin
				gs_vld_q[cmd.led] <= 1'b1;
			end
			if (dc_we) begin
				dc_vld_q[dc_row_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		ctrl_s1 <= frame_ctrl_q;
		last_s1 <= step_q == last_step;
		rvld_s1 <= frame_ctrl_q ? dc_vld_q[frame_row] : gs_vld_q[frame_row];
		if (accept) begin
			dc_row_q  <= cmd_row[lds_pkg::ROW_AW-1:0];
			dc_slot_q <= cmd_slot;
			dc_val_q  <= cmd.dc_value;
		end
	end

	// grayscale store: one LED per row, {blue, green, red}
	assign gs_we = accept && cmd.kind == lds_pkg::KIND_GS;

	lds_ram #(
		.WIDTH (lds_pkg::GS_ROW_W),
		.DEPTH (lds_pkg::NUM_LEDS)
	) u_gs_ram (
		.clk   (clk),
		.we    (gs_we),
		.waddr (cmd.led),
		.wdata ({cmd.blue, cmd.green, cmd.red}),
		.raddr (frame_row),
		.rdata (gs_rdata)
	);

	// dot-correction store: three entries per row, read-modify-write on update
	assign dc_we    = state_q == lds_pkg::ST_DCWR;
	assign dc_raddr = (state_q == lds_pkg::ST_IDLE) ? cmd_row[lds_pkg::ROW_AW-1:0] : frame_row;
	assign dc_base  = dc_vld_q[dc_row_q] ? dc_rdata : {3{lds_pkg::DC_RESET}};

	always_comb begin
		dc_wdata = dc_base;
		unique case (dc_slot_q)
			2'd0:    dc_wdata[0*lds_pkg::DC_W +: lds_pkg::DC_W] = dc_val_q;
			2'd1:    dc_wdata[1*lds_pkg::DC_W +: lds_pkg::DC_W] = dc_val_q;
			2'd2:    dc_wdata[2*lds_pkg::DC_W +: lds_pkg::DC_W] = dc_val_q;
			default: dc_wdata = dc_base;
		endcase
	end

	lds_ram #(
		.WIDTH (lds_pkg::DC_ROW_W),
		.DEPTH (lds_pkg::NUM_LEDS)
	) u_dc_ram (
		.clk   (clk),
		.we    (dc_we),
		.waddr (dc_row_q),
		.wdata (dc_wdata),
		.raddr (dc_raddr),
		.rdata (dc_rdata)
	);

	// build the push for this step
	always_comb begin
		push      = '0;
		push.vld  = vld_s1;
		push.last = last_s1;
		if (!ctrl_s1) begin
			if (step_s1 == lds_pkg::STEP_HEAD) begin
				push.len = lds_pkg::LEN_GS_HEAD;
			end else begin
				push.len  = lds_pkg::LEN_FULL;
				push.data = rvld_s1 ? gs_rdata : '0;
			end
		end else begin
			priority if (step_s1 == lds_pkg::STEP_HEAD) begin
				push.len  = lds_pkg::LEN_CT_HEAD;
				push.data = {1'b1, lds_pkg::CTRL_MAGIC, 39'b0};
			end else if (step_s1 <= lds_pkg::CT_ONES_LAST) begin
				push.len  = lds_pkg::LEN_FULL;
				push.data = '1;
			end else if (step_s1 == lds_pkg::CT_ONES_TAIL) begin
				push.len  = lds_pkg::LEN_ONES;
				push.data = {5'b11111, 43'b0};
			end else if (step_s1 == lds_pkg::CT_CFG_STEP) begin
				push.len  = lds_pkg::LEN_CFG;
				push.data = {fn_q, bw_q, mc_q, 13'b0};
			end else begin
				push.len  = lds_pkg::LEN_DC_ROW;
				push.data = {(rvld_s1 ? dc_rdata : {3{lds_pkg::DC_RESET}}), 27'b0};
			end
		end
	end

	lds_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.strobe (strobe),
		.result (result),
		.fin    (pk_fin)
	);

	// the latched chunk closes the transaction
	a_latch_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.latch |-> !busy)
		else $error("busy still high on final chunk");

	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.bit_count == lds_pkg::CHUNK_CNT || result.latch)
		else $error("short chunk without latch");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without a command");

	a_no_idle_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld |-> state_q == lds_pkg::ST_RUN)
		else $error("push outside a frame");

endmodule

`default_nettype wire

// ===== tb/led_driver_frame_serializer_test.sv =====
// Self-checking testbench for led_driver_frame_serializer: a command driver with bursty
// gaps, a chunk monitor, register writes between phases and a predictor of every frame.
// Depends on lds_pkg and the led_driver_frame_serializer RTL.
`default_nettype none

module led_driver_frame_serializer_test;

	localparam logic [1:0] KIND_SPARE    = 2'd3;  // unused kind, must be ignored
	localparam logic [1:0] REG_SPARE     = 2'd3;  // no register at this index
	localparam int         FRAME_LEN     = 769;
	localparam int         CHUNKS        = 13;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         LIMIT_CYCLES  = 200000;
	localparam int         PHASES        = 6;
	localparam int         PHASE_ITEMS   = 49;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	lds_pkg::cmd_t              cmd = '0;
	logic                       strobe;
	lds_pkg::result_t           result;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = lds_pkg::REG_FUNC;
	logic [lds_pkg::CFG_DW-1:0] cfg_data = '0;

	// predictor state
	logic [lds_pkg::GS_W-1:0] gray_mirror [lds_pkg::DC_ENTRIES];
	logic [lds_pkg::DC_W-1:0] dc_mirror   [lds_pkg::DC_ENTRIES];
	logic [4:0]      func_mirror;
	logic [20:0]     brt_mirror;
	logic [8:0]      maxc_mirror;

	lds_pkg::cmd_t    cmd_backlog [$];
	lds_pkg::result_t chunks_due  [$];
	logic    holding = 1'b0;   // a command has left the backlog but is not yet taken
	int      burst_left = 0;
	int      gap_left = 0;
	int      errors = 0;
	int      seen = 0;
	int      cycles = 0;

	led_driver_frame_serializer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	// apply one command to the mirror and queue the chunks it should produce
	task automatic predict_frames(input lds_pkg::cmd_t c);
		logic [FRAME_LEN-1:0] frame;
		logic                 send;
		lds_pkg::result_t     r;
		int                   n;
		send = 1'b0;
		frame = '0;
		if (c.kind == lds_pkg::KIND_GS) begin
			gray_mirror[int'(c.led) * 3]     = c.red;
			gray_mirror[int'(c.led) * 3 + 1] = c.green;
			gray_mirror[int'(c.led) * 3 + 2] = c.blue;
			for (n = 0; n < lds_pkg::DC_ENTRIES; n++)
				frame[n * lds_pkg::GS_W +: lds_pkg::GS_W] = gray_mirror[n];
			send = 1'b1;
		end else if (c.kind == lds_pkg::KIND_DC) begin
			if (c.dc_index < lds_pkg::DC_ENTRIES)
				dc_mirror[c.dc_index] = c.dc_value;
		end else if (c.kind == lds_pkg::KIND_CTRL) begin
			frame = {1'b1, lds_pkg::CTRL_MAGIC, {389{1'b1}}, func_mirror, brt_mirror,
				maxc_mirror, 336'b0};
			for (n = 0; n < lds_pkg::DC_ENTRIES; n++)
				frame[n * lds_pkg::DC_W +: lds_pkg::DC_W] = dc_mirror[n];
			send = 1'b1;
		end
		if (send) begin
			// first sent bit is frame[FRAME_LEN-1]
			for (n = 0; n < CHUNKS - 1; n++) begin
				r.frame_chunk = frame[705 - 64 * n +: 64];
				r.bit_count   = lds_pkg::CHUNK_CNT;
				r.latch       = 1'b0;
				chunks_due.push_back(r);
			end
			// trailing single bit carries the latch
			r.frame_chunk = {frame[0], 63'b0};
			r.bit_count   = 7'd1;
			r.latch       = 1'b1;
			chunks_due.push_back(r);
		end
	endtask

	task automatic queue_cmd(input logic [1:0] kind, input logic [3:0] led,
			input logic [15:0] red, input logic [15:0] green, input logic [15:0] blue,
			input logic [5:0] dc_index, input logic [6:0] dc_value);
		lds_pkg::cmd_t c;
		c.kind     = kind;
		c.led      = led;
		c.red      = red;
		c.green    = green;
		c.blue     = blue;
		c.dc_index = dc_index;
		c.dc_value = dc_value;
		cmd_backlog.push_back(c);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [lds_pkg::CFG_DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			lds_pkg::REG_FUNC: func_mirror = val[4:0];
			lds_pkg::REG_BRT:  brt_mirror  = val[20:0];
			lds_pkg::REG_MAXC: maxc_mirror = val[8:0];
			default:  ;
		endcase
	endtask

	// block idle: nothing queued, nothing in flight, all chunks seen
	task automatic settle();
		while (cmd_backlog.size() != 0 || holding || chunks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				predict_frames(cmd);
				holding = 1'b0;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					start <= 1'b0;
				end else begin
					cmd <= cmd_backlog.pop_front();
					holding = 1'b1;
					start <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : chunk_monitor
		lds_pkg::result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (chunks_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected chunk %h/%0d/%b",
					result.frame_chunk, result.bit_count, result.latch));
			end else begin
				want = chunks_due.pop_front();
				if (result.frame_chunk !== want.frame_chunk)
					flag_mismatch($sformatf("chunk %0d frame_chunk got %h want %h", seen,
						result.frame_chunk, want.frame_chunk));
				if (result.bit_count !== want.bit_count)
					flag_mismatch($sformatf("chunk %0d bit_count got %0d want %0d", seen,
						result.bit_count, want.bit_count));
				if (result.latch !== want.latch)
					flag_mismatch($sformatf("chunk %0d latch got %b want %b", seen,
						result.latch, want.latch));
			end
			seen++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("led_driver_frame_serializer_test: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int p;
		int i;
		int pick;
		logic [5:0] idx;
		for (i = 0; i < lds_pkg::DC_ENTRIES; i++) begin
			gray_mirror[i] = '0;
			dc_mirror[i]   = lds_pkg::DC_RESET;
		end
		func_mirror = lds_pkg::FUNC_RESET;
		brt_mirror  = lds_pkg::BRT_RESET;
		maxc_mirror = lds_pkg::MAXC_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset register values, field extremes, ignored writes and kinds
		queue_cmd(lds_pkg::KIND_CTRL, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_GS, 4'd0, 16'hffff, 16'hffff, 16'hffff, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_GS, 4'd15, 16'hffff, 16'h0000, 16'h8001, 6'h3f, 7'h7f);
		queue_cmd(lds_pkg::KIND_GS, 4'd7, 16'haaaa, 16'h5555, 16'h1234, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_GS, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_DC, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_DC, 4'd0, 16'h0, 16'h0, 16'h0, 6'd47, 7'h55);
		queue_cmd(lds_pkg::KIND_DC, 4'd0, 16'h0, 16'h0, 16'h0, 6'd1, 7'h2a);
		queue_cmd(lds_pkg::KIND_DC, 4'd0, 16'h0, 16'h0, 16'h0, 6'd48, 7'd0);
		queue_cmd(lds_pkg::KIND_DC, 4'hf, 16'hffff, 16'hffff, 16'hffff, 6'd63, 7'd0);
		queue_cmd(lds_pkg::KIND_CTRL, 4'hf, 16'hffff, 16'hffff, 16'hffff, 6'h3f, 7'h7f);
		queue_cmd(KIND_SPARE, 4'hf, 16'hffff, 16'hffff, 16'hffff, 6'd5, 7'd0);
		queue_cmd(KIND_SPARE, 4'd2, 16'h1111, 16'h2222, 16'h3333, 6'h3f, 7'h7f);
		queue_cmd(lds_pkg::KIND_GS, 4'd15, 16'h0, 16'h0, 16'h0, 6'd0, 7'd0);
		queue_cmd(lds_pkg::KIND_CTRL, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 7'd0);
		settle();

		for (p = 0; p < PHASES; p++) begin
			// first all zero, then all ones beyond the widths, then random words
			if (p == 0) begin
				write_reg(lds_pkg::REG_FUNC, '0);
				write_reg(lds_pkg::REG_BRT, '0);
				write_reg(lds_pkg::REG_MAXC, '0);
			end else if (p == 1) begin
				write_reg(lds_pkg::REG_MAXC, '1);
				write_reg(lds_pkg::REG_FUNC, '1);
				write_reg(lds_pkg::REG_BRT, '1);
			end else begin
				write_reg(lds_pkg::REG_BRT, $urandom());
				write_reg(lds_pkg::REG_MAXC, $urandom());
				write_reg(lds_pkg::REG_FUNC, $urandom());
			end
			if (p % 2 == 0)
				write_reg(REG_SPARE, $urandom());

			for (i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 19);
				idx = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(48, 63))
					: 6'($urandom_range(0, 47));
				queue_cmd((pick < 8) ? lds_pkg::KIND_GS : (pick < 13) ? lds_pkg::KIND_DC :
					(pick < 19) ? lds_pkg::KIND_CTRL : KIND_SPARE,
					4'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
					idx, 7'($urandom()));
			end
			settle();
		end

		if (errors == 0)
			$display("led_driver_frame_serializer_test: PASS");
		else
			$display("led_driver_frame_serializer_test: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
